[design/dq_pkg.sv]
// shared types, sizes and codes for the double ended queue
// depends on nothing; used by every module in the design folder
package dq_pkg;

	// ring size and derived widths
	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 4;
	localparam int STAT_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ_IDX   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_WRITE_IDX  = 3'd6;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd7;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	// ring port request from the sequencer
	typedef struct packed {
		logic                     we;
		logic [IDX_W-1:0]         waddr;
		logic signed [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]         raddr;
	} ring_req_t;

	// one result beat
	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic                     found;
		logic [STAT_W-1:0]        status;
		logic [CNT_W-1:0]         item_total;
	} result_t;

endpackage

[design/dq_ring.sv]
// ring storage: one write port, one read port with registered read data
// depends on dq_pkg
module dq_ring
	import dq_pkg::*;
(
	input  logic                     clk,
	input  ring_req_t                req,
	output logic signed [DATA_W-1:0] rd_data
);

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		rd_data <= mem_q[req.raddr];
	end

endmodule

[design/dq_seq.sv]
// sequencer: front and count registers, shared slot adder and compare unit
// depends on dq_pkg; drives the ring request of dq_ring
module dq_seq
	import dq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] data_value,
	input  logic [POS_W-1:0]         position,
	output ring_req_t                ring_req,
	input  logic signed [DATA_W-1:0] rd_data,
	output logic                     res_valid,
	input  logic                     res_take,
	output result_t                  res
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_SRCH = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

	logic [1:0]               state_q;
	logic [IDX_W-1:0]         front_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         idx_q;
	logic                     cmp_v_q;
	logic signed [DATA_W-1:0] val_q;
	result_t                  res_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic             pos_bad;
	logic [CNT_W-1:0] off;
	logic [CNT_W-1:0] sum;
	logic [IDX_W-1:0] slot;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic             hit;

	assign accept  = in_valid && (state_q == S_IDLE);
	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign pos_bad = (32'(position) >= 32'(count_q));
	assign hit     = cmp_v_q && (rd_data == val_q);

	assign front_dec = (front_q == '0) ? IDX_LAST : front_q - 1'b1;
	assign front_inc = (front_q == IDX_LAST) ? '0 : front_q + 1'b1;

	// offset into the ring, chosen by command or by the search walk
	always_comb begin
		off = '0;
		if (state_q == S_SRCH) begin
			off = idx_q;
		end else begin
			unique case (command)
				CMD_PUSH_BACK:  off = count_q;
				CMD_POP_BACK:   off = count_q - 1'b1;
				CMD_READ_IDX,
				CMD_WRITE_IDX:  off = CNT_W'(position);
				default:        off = '0;
			endcase
		end
	end

	// shared slot adder with wrap
	assign sum  = CNT_W'(front_q) + off;
	assign slot = (sum >= CNT_FULL) ? IDX_W'(sum - CNT_FULL) : IDX_W'(sum);

	// ring request
	always_comb begin
		ring_req.we    = 1'b0;
		ring_req.waddr = slot;
		ring_req.wdata = data_value;
		ring_req.raddr = slot;
		if (accept) begin
			unique case (command)
				CMD_PUSH_FRONT: begin
					ring_req.we    = !full;
					ring_req.waddr = front_dec;
				end
				CMD_PUSH_BACK:  ring_req.we = !full;
				CMD_WRITE_IDX:  ring_req.we = !empty && !pos_bad;
				default:        ring_req.we = 1'b0;
			endcase
		end
	end

	// sequencer and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
			cmp_v_q <= 1'b0;
			val_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q                <= data_value;
						res_q.read_value     <= '0;
						res_q.found          <= 1'b0;
						res_q.status         <= ST_OK;
						res_q.item_total     <= count_q;
						state_q              <= S_DONE;
						unique case (command)
							CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
								if (full) begin
									res_q.status <= ST_FULL;
								end else begin
									if (command == CMD_PUSH_FRONT) begin
										front_q <= front_dec;
									end
									count_q          <= count_q + 1'b1;
									res_q.item_total <= count_q + 1'b1;
								end
							end
							CMD_POP_FRONT, CMD_POP_BACK: begin
								if (empty) begin
									res_q.status <= ST_EMPTY;
								end else begin
									if (command == CMD_POP_FRONT) begin
										front_q <= front_inc;
									end
									count_q          <= count_q - 1'b1;
									res_q.item_total <= count_q - 1'b1;
									state_q          <= S_READ;
								end
							end
							CMD_SEARCH: begin
								idx_q   <= '0;
								cmp_v_q <= 1'b0;
								state_q <= S_SRCH;
							end
							CMD_READ_IDX, CMD_WRITE_IDX: begin
								if (empty) begin
									res_q.status <= ST_EMPTY;
								end else if (pos_bad) begin
									res_q.status <= ST_RANGE;
								end else if (command == CMD_READ_IDX) begin
									state_q <= S_READ;
								end
							end
							CMD_CLEAR: begin
								front_q          <= '0;
								count_q          <= '0;
								res_q.item_total <= '0;
							end
						endcase
					end
				end
				S_READ: begin
					res_q.read_value <= rd_data;
					state_q          <= S_DONE;
				end
				S_SRCH: begin
					// compare the entry read last cycle, else fetch the next
					if (hit) begin
						res_q.found <= 1'b1;
						cmp_v_q     <= 1'b0;
						state_q     <= S_DONE;
					end else if (idx_q >= count_q) begin
						cmp_v_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						cmp_v_q <= 1'b1;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

[design/double_ended_queue_top.sv]
// Bounded double ended queue of signed 32-bit values held in a 16-entry ring.
// One command is worked on at a time and in_stall stays high meanwhile. Pop and read
// by index wait for the registered ring read; search walks the stored items one per
// cycle through the single ring read port and stops early on a hit. The result beat
// enters the output register as the sequencer returns to idle, before the next
// command can be taken.
// The output register lets a new command be accepted while a result beat waits.
// depends on dq_pkg, dq_ring, dq_seq
module double_ended_queue_top
	import dq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] data_value,
	input  logic [POS_W-1:0]         position,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] read_value,
	output logic                     found,
	output logic [STAT_W-1:0]        status,
	output logic [CNT_W-1:0]         item_total
);

	ring_req_t                ring_req;
	logic signed [DATA_W-1:0] rd_data;
	logic                     res_valid;
	logic                     res_take;
	result_t                  res;
	logic                     out_valid_q;
	result_t                  out_q;

	dq_ring u_ring (
		.clk     (clk),
		.req     (ring_req),
		.rd_data (rd_data)
	);

	dq_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.data_value (data_value),
		.position   (position),
		.ring_req   (ring_req),
		.rd_data    (rd_data),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	// output register for the result beat
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_q.read_value;
	assign found      = out_q.found;
	assign status     = out_q.status;
	assign item_total = out_q.item_total;

	// the block goes busy right after taking a command
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("command accepted while not going busy");

	// count never exceeds the ring size
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> item_total <= CNT_W'(DEPTH))
		else $error("item total above capacity");

	// full status only reported with a full ring
	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> item_total == CNT_W'(DEPTH))
		else $error("full status with room left");

	// a hit only comes with ok status and no read value
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == ST_OK && read_value == '0)
		else $error("found set on a non search result");

endmodule

[tb/sv/tb.sv]
// self-checking testbench for double_ended_queue_top: directed table, then random phases
// keeps its own ring model to predict each result beat the table does not type in; depends on dq_pkg and the design
module tb;
	import dq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// directed stimulus row, with an optional typed-in result
	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] data;
		logic [POS_W-1:0]         pos;
		logic                     typed;
		result_t                  want;
	} dir_row_t;

	typedef enum {PH_FILL, PH_DRAIN, PH_ACCESS, PH_NOISE} phase_t;

	localparam int RAND_ITEMS = 1650;
	localparam int DIR_N      = 24;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [CMD_W-1:0]         command = CMD_PUSH_BACK;
	logic signed [DATA_W-1:0] data_value = '0;
	logic [POS_W-1:0]         position = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] read_value;
	logic                     found;
	logic [STAT_W-1:0]        status;
	logic [CNT_W-1:0]         item_total;

	// ring model state
	logic signed [DATA_W-1:0] model_ring [DEPTH];
	logic [IDX_W-1:0]         model_front = '0;
	logic [CNT_W-1:0]         model_count = '0;

	result_t pending_results [$];
	int      err_count = 0;
	int      rx_burst = 0;
	logic    long_hold = 1'b0;
	logic    hold_go = 1'b0;
	logic    no_idle = 1'b0;

	dir_row_t dir_tab [DIR_N] = '{
		'{CMD_POP_FRONT,  32'sd0,           4'd0,  1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}},
		'{CMD_POP_BACK,   32'sd0,           4'd0,  1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}},
		'{CMD_READ_IDX,   32'sd0,           4'd0,  1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}},
		'{CMD_WRITE_IDX,  32'sd5,           4'd15, 1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}},
		'{CMD_SEARCH,     32'sd0,           4'd0,  1'b1, '{32'sd0, 1'b0, ST_OK, 5'd0}},
		'{CMD_PUSH_BACK,  32'sh7fffffff,    4'd0,  1'b1, '{32'sd0, 1'b0, ST_OK, 5'd1}},
		'{CMD_PUSH_FRONT, 32'sh80000000,    4'd0,  1'b1, '{32'sd0, 1'b0, ST_OK, 5'd2}},
		'{CMD_READ_IDX,   32'sd0,           4'd0,  1'b1,
			'{32'sh80000000, 1'b0, ST_OK, 5'd2}},
		'{CMD_READ_IDX,   32'sd0,           4'd1,  1'b1,
			'{32'sh7fffffff, 1'b0, ST_OK, 5'd2}},
		'{CMD_READ_IDX,   32'sd0,           4'd2,  1'b1, '{32'sd0, 1'b0, ST_RANGE, 5'd2}},
		'{CMD_WRITE_IDX,  32'sh00001234,    4'd15, 1'b1, '{32'sd0, 1'b0, ST_RANGE, 5'd2}},
		'{CMD_WRITE_IDX,  -32'sd1,          4'd1,  1'b0, '0},
		'{CMD_SEARCH,     -32'sd1,          4'd0,  1'b0, '0},
		'{CMD_SEARCH,     32'sd0,           4'd0,  1'b0, '0},
		'{CMD_PUSH_BACK,  32'sd0,           4'd0,  1'b0, '0},
		'{CMD_SEARCH,     32'sh7fffffff,    4'd0,  1'b0, '0},
		'{CMD_POP_BACK,   32'sd0,           4'd0,  1'b0, '0},
		'{CMD_POP_BACK,   32'sd0,           4'd0,  1'b0, '0},
		'{CMD_POP_FRONT,  32'sd0,           4'd0,  1'b0, '0},
		'{CMD_POP_FRONT,  32'sd0,           4'd0,  1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}},
		'{CMD_PUSH_FRONT, 32'sh55555555,    4'd0,  1'b0, '0},
		'{CMD_PUSH_BACK,  32'shaaaaaaaa,    4'd0,  1'b0, '0},
		'{CMD_CLEAR,      32'sd0,           4'd0,  1'b1, '{32'sd0, 1'b0, ST_OK, 5'd0}},
		'{CMD_READ_IDX,   32'sd0,           4'd3,  1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}}
	};

	double_ended_queue_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.data_value (data_value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.found      (found),
		.status     (status),
		.item_total (item_total)
	);

	always #5 clk = ~clk;

	// ring index of the item at an offset from the front
	function automatic logic [IDX_W-1:0] ring_slot(input int unsigned offset);
		return IDX_W'((model_front + offset) % DEPTH);
	endfunction

	// advance the ring model by one command and give the result it causes
	task automatic dq_apply(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val,
			input logic [POS_W-1:0] pos, output result_t res);
		logic [IDX_W-1:0] s;
		res = '0;
		case (cmd)
			CMD_PUSH_FRONT: begin
				if (model_count >= DEPTH) res.status = ST_FULL;
				else begin
					model_front = IDX_W'((model_front + DEPTH - 1) % DEPTH);
					model_ring[model_front] = val;
					model_count = model_count + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (model_count >= DEPTH) res.status = ST_FULL;
				else begin
					model_ring[ring_slot(model_count)] = val;
					model_count = model_count + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (model_count == 0) res.status = ST_EMPTY;
				else begin
					res.read_value = model_ring[model_front];
					model_front = IDX_W'((model_front + 1) % DEPTH);
					model_count = model_count - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (model_count == 0) res.status = ST_EMPTY;
				else begin
					res.read_value = model_ring[ring_slot(model_count - 1)];
					model_count = model_count - 1'b1;
				end
			end
			CMD_SEARCH: begin
				for (int i = 0; i < model_count; i++) begin
					if (model_ring[ring_slot(i)] == val) begin
						res.found = 1'b1;
						break;
					end
				end
			end
			CMD_READ_IDX, CMD_WRITE_IDX: begin
				if (model_count == 0) res.status = ST_EMPTY;
				else if (pos >= model_count) res.status = ST_RANGE;
				else begin
					s = ring_slot(pos);
					if (cmd == CMD_READ_IDX) res.read_value = model_ring[s];
					else model_ring[s] = val;
				end
			end
			default: begin
				model_front = '0;
				model_count = '0;
			end
		endcase
		res.item_total = model_count;
	endtask

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		err_count++;
		if (err_count <= 100)
			$display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
	endtask

	// offer one command beat, hold it until taken, then maybe leave a gap
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val,
			input logic [POS_W-1:0] pos, input logic typed, input result_t want);
		result_t pred;
		command    <= cmd;
		data_value <= val;
		position   <= pos;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		dq_apply(cmd, val, pos, pred);
		pending_results.push_back(typed ? want : pred);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// data value: extremes, small values that repeat, or anything
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'sh80000000;
					1: return 32'sh7fffffff;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			1, 2: return DATA_W'($signed($urandom_range(0, 8)) - 4);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// long receiver hold-off so the block fills and stalls its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (150) @(posedge clk);
		long_hold <= 1'b0;
	end

	// result side: check each accepted beat, then pick the next stall
	always @(posedge clk) begin : rx_side
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) report_mismatch("unexpected beat", '0, '0);
			else begin
				want = pending_results.pop_front();
				if (read_value !== want.read_value)
					report_mismatch("read_value", read_value, want.read_value);
				if (found !== want.found) report_mismatch("found", found, want.found);
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (item_total !== want.item_total)
					report_mismatch("item_total", item_total, want.item_total);
			end
		end
		if (long_hold) out_stall <= 1'b1;
		else if (no_idle) out_stall <= 1'b0;
		else if (rx_burst > 0) begin
			out_stall <= 1'b1;
			rx_burst  <= rx_burst - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			rx_burst  <= $urandom_range(0, 5);
		end else out_stall <= 1'b0;
	end

	// stimulus: reset, directed table, random phases, drain
	initial begin : stim
		phase_t                   ph;
		int                       plen;
		int                       rand_sent;
		int                       r;
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] val;
		logic [POS_W-1:0]         pos;
		rand_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_cmd(dir_tab[i].cmd, dir_tab[i].data, dir_tab[i].pos, dir_tab[i].typed,
				dir_tab[i].want);

		while (rand_sent < RAND_ITEMS) begin
			// start with a fill so full is reached early
			if (rand_sent == 0) begin
				ph   = PH_FILL;
				plen = 24;
			end else begin
				ph   = phase_t'($urandom_range(0, 3));
				plen = $urandom_range(10, 60);
			end
			for (int k = 0; k < plen && rand_sent < RAND_ITEMS; k++) begin
				r = $urandom_range(0, 9);
				case (ph)
					PH_FILL: cmd = (r < 4) ? CMD_PUSH_BACK : (r < 7) ? CMD_PUSH_FRONT :
						(r == 7) ? CMD_SEARCH : (r == 8) ? CMD_READ_IDX : CMD_WRITE_IDX;
					PH_DRAIN: cmd = (r < 3) ? CMD_POP_FRONT : (r < 6) ? CMD_POP_BACK :
						(r == 6) ? CMD_PUSH_BACK : (r == 7) ? CMD_READ_IDX :
						(r == 8) ? CMD_SEARCH : CMD_WRITE_IDX;
					PH_ACCESS: cmd = (r == 0) ? CMD_PUSH_FRONT : (r == 1) ? CMD_PUSH_BACK :
						(r < 4) ? CMD_READ_IDX : (r < 6) ? CMD_WRITE_IDX :
						(r < 8) ? CMD_SEARCH : (r == 8) ? CMD_POP_FRONT : CMD_POP_BACK;
					default: cmd = CMD_W'($urandom_range(0, 7));
				endcase
				if (ph != PH_NOISE && $urandom_range(0, 49) == 0) cmd = CMD_CLEAR;

				// search mostly for something held, index mostly in range
				val = pick_value();
				if (cmd == CMD_SEARCH && model_count > 0 && $urandom_range(0, 1) == 0)
					val = model_ring[ring_slot($urandom_range(0, model_count - 1))];
				pos = POS_W'($urandom_range(0, 15));
				if ((cmd == CMD_READ_IDX || cmd == CMD_WRITE_IDX) && model_count > 0 &&
						$urandom_range(0, 3) != 0)
					pos = POS_W'($urandom_range(0, model_count - 1));

				send_cmd(cmd, val, pos, 1'b0, '0);
				rand_sent++;

				if (rand_sent == 400) hold_go <= 1'b1;
				if (rand_sent == 800) begin
					in_valid <= 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end
				if (rand_sent == RAND_ITEMS - 150) no_idle <= 1'b1;
			end
		end

		// drain and let the block settle
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0) $display("tb: done, clean");
		else $display("tb: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("tb: done, errors");
		$finish;
	end

endmodule
